FILE: rtl/core/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and byte-building helpers for the UTF-16 to UTF-8
// encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned UNIT_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_BYTES   = 6;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Top six bits of the two surrogate ranges.
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  localparam logic [7:0]  LEAD1_LIM = 8'h80;
  localparam logic [11:0] LEAD2_LIM = 12'h800;
  localparam logic [7:0]  CONT_TAG  = 8'h80;
  localparam logic [7:0]  LEAD2_TAG = 8'hC0;
  localparam logic [7:0]  LEAD3_TAG = 8'hE0;
  localparam logic [7:0]  LEAD4_TAG = 8'hF0;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  typedef logic [2:0][BYTE_W-1:0] trio_t;

  // One unit's worth of output bytes; entry 0 goes out first.
  typedef struct packed {
    logic [CNT_W-1:0]                     n_bytes;
    logic                                 last;
    logic [MAX_BYTES-1:0][BYTE_W-1:0]     bytes;
  } job_t;

  function automatic trio_t enc3(input logic [UNIT_W-1:0] v);
    trio_t t;
    t[0] = LEAD3_TAG | {4'h0, v[15:12]};
    t[1] = CONT_TAG  | {2'b00, v[11:6]};
    t[2] = CONT_TAG  | {2'b00, v[5:0]};
    return t;
  endfunction

endpackage

FILE: rtl/core/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Classifies each code unit, tracks a held high surrogate and builds the
// list of bytes that the unit completes.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               take,
  input  logic [u16u8_pkg::UNIT_W-1:0]       code_unit,
  input  logic                               last_unit,
  output logic                               push,
  output u16u8_pkg::job_t                    job
);

  logic       pend_r, pend_nxt;
  logic [9:0] hb_r, hb_nxt;

  logic                   is_low, is_high;
  logic [20:0]            cp;
  u16u8_pkg::trio_t       mb;
  u16u8_pkg::trio_t       held3;
  logic [1:0]             nm;

  always_comb begin
    is_low  = (code_unit[15:10] == u16u8_pkg::LOW_SURR_TAG);
    is_high = (code_unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
    cp      = {1'b0, hb_r, code_unit[9:0]} + u16u8_pkg::SUPP_BASE;
    held3   = u16u8_pkg::enc3({u16u8_pkg::HIGH_SURR_TAG, hb_r});
    pend_nxt = 1'b0;
    hb_nxt   = '0;
    mb       = '0;
    nm       = 2'd0;
    job.last  = last_unit;
    job.bytes = '0;
    job.n_bytes = '0;

    if (pend_r && is_low) begin
      job.bytes[0] = u16u8_pkg::LEAD4_TAG | {5'h00, cp[20:18]};
      job.bytes[1] = u16u8_pkg::CONT_TAG  | {2'b00, cp[17:12]};
      job.bytes[2] = u16u8_pkg::CONT_TAG  | {2'b00, cp[11:6]};
      job.bytes[3] = u16u8_pkg::CONT_TAG  | {2'b00, cp[5:0]};
      job.n_bytes  = 3'd4;
    end else begin
      if (code_unit < 16'(u16u8_pkg::LEAD1_LIM)) begin
        mb[0] = code_unit[7:0];
        nm    = 2'd1;
      end else if (code_unit < 16'(u16u8_pkg::LEAD2_LIM)) begin
        mb[0] = u16u8_pkg::LEAD2_TAG | {3'b000, code_unit[10:6]};
        mb[1] = u16u8_pkg::CONT_TAG  | {2'b00, code_unit[5:0]};
        nm    = 2'd2;
      end else if (is_high && !last_unit) begin
        pend_nxt = 1'b1;
        hb_nxt   = code_unit[9:0];
      end else begin
        mb = u16u8_pkg::enc3(code_unit);
        nm = 2'd3;
      end

      // A held surrogate without its partner goes out first as three bytes.
      if (pend_r) begin
        job.bytes[2:0] = held3;
        job.bytes[5:3] = mb;
        job.n_bytes    = 3'd3 + {1'b0, nm};
      end else begin
        job.bytes[2:0] = mb;
        job.n_bytes    = {1'b0, nm};
      end
    end
  end

  assign push = take && (job.n_bytes != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      hb_r   <= '0;
    end else if (take) begin
      pend_r <= pend_nxt;
      hb_r   <= hb_nxt;
    end
  end

endmodule

FILE: rtl/core/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Short register queue of byte jobs between the front and back parts.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output u16u8_pkg::job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u16u8_pkg::job_t        mem_r [DEPTH];
  logic [PTR_W-1:0]       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/core/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Steps through each byte job and drives one registered output beat per
// cycle while out_ready is high, taking the next job without a gap.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_valid,
  input  u16u8_pkg::job_t                 job_in,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [u16u8_pkg::BYTE_W-1:0]    out_byte,
  output logic                            out_last_of_run,
  output logic                            out_string_end
);

  u16u8_pkg::job_t              job_r;
  logic                         busy_r, busy_nxt;
  logic [u16u8_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                         vld_r, vld_nxt;
  logic [u16u8_pkg::BYTE_W-1:0] byte_r;
  logic                         lor_r, end_r;

  logic                         load_out, emit, fin;
  u16u8_pkg::job_t              src;
  logic [u16u8_pkg::CNT_W-1:0]  src_idx;

  always_comb begin
    load_out = !vld_r || out_ready;
    src      = busy_r ? job_r : job_in;
    src_idx  = busy_r ? idx_r : '0;
    emit     = load_out && (busy_r || job_valid);
    fin      = (src_idx == (src.n_bytes - 1'b1));
    pop      = load_out && !busy_r && job_valid;

    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    if (load_out) begin
      vld_nxt = emit;
    end
    if (emit) begin
      busy_nxt = !fin;
      idx_nxt  = src_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job_in;
    end
    if (emit) begin
      byte_r <= src.bytes[src_idx];
      lor_r  <= fin;
      end_r  <= fin && src.last;
    end
  end

  assign out_valid       = vld_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = lor_r;
  assign out_string_end  = end_r;

endmodule

FILE: rtl/core/utf16_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// Converts a stream of UTF-16 code units into a stream of UTF-8 bytes.
// ----------------------------------------------------------------------------
//  Channel | Ports                                         | Direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_ready, in_code_unit, in_last_unit | sink
//  out     | out_valid, out_ready, out_byte,                | source
//          | out_last_of_run, out_string_end               |
//
//  The output gives one byte beat per cycle while out_ready is high. A unit
//  completes 1 to 3 bytes for most text, 4 for a surrogate pair, up to 6
//  when a held surrogate is flushed, and none when it is only held.
//  A unit is accepted in any cycle where the job queue has room; the byte
//  stepper in the back part sets the sustained rate.
//  Reset clears the held surrogate, the queue and the output valid flag.
//  An output stall fills the queue and then holds in_ready low.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder #(
  parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [u16u8_pkg::UNIT_W-1:0]     in_code_unit,
  input  logic                             in_last_unit,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [u16u8_pkg::BYTE_W-1:0]     out_byte,
  output logic                             out_last_of_run,
  output logic                             out_string_end
);

  logic            take, push, pop, full, not_empty;
  u16u8_pkg::job_t new_job, head_job;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .code_unit (in_code_unit),
    .last_unit (in_last_unit),
    .push      (push),
    .job       (new_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (new_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head_job)
  );

  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (not_empty),
    .job_in          (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_string_end  (out_string_end)
  );

endmodule
